// ===== design/unsorted_list_table_top_assert.svh =====
// assertion macros shared by the checker
`ifndef UNSORTED_LIST_TABLE_TOP_ASSERT_SVH
`define UNSORTED_LIST_TABLE_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define ULT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define ULT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ult_pkg.sv =====
package ult_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam op_t OP_PUT     = 3'd0;
    localparam op_t OP_GET     = 3'd1;
    localparam op_t OP_DELETE  = 3'd2;
    localparam op_t OP_CLEAR   = 3'd3;
    localparam op_t OP_RESTART = 3'd4;
    localparam op_t OP_NEXT    = 3'd5;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_FULL      = 2'd1;
    localparam status_t STAT_NOT_FOUND = 2'd2;
    localparam status_t STAT_PAST_END  = 2'd3;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic next_mode;
        logic wr_en;
    } cell_ctl_t;

endpackage

// ===== design/ult_cell.sv =====
module ult_cell #(
    parameter int ITEM_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  ult_pkg::cell_ctl_t    ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [CNT_W-1:0]      cursor,
    input  logic [ITEM_WIDTH-1:0] word,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [ITEM_WIDTH-1:0] wr_data,
    input  logic                  found_in,
    input  logic [IDX_W-1:0]      pos_in,
    input  logic [ITEM_WIDTH-1:0] hit_in,
    input  logic [ITEM_WIDTH-1:0] last_in,
    output logic                  found_out,
    output logic [IDX_W-1:0]      pos_out,
    output logic [ITEM_WIDTH-1:0] hit_out,
    output logic [ITEM_WIDTH-1:0] last_out
);
    import ult_pkg::*;

    localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_SUCC = CNT_W'(INDEX + 1);
    localparam logic [IDX_W-1:0] MY_POS  = IDX_W'(INDEX);

    logic [ITEM_WIDTH-1:0] entry_reg;
    logic                  found_reg;
    logic                  found_next;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      pos_next;
    logic [ITEM_WIDTH-1:0] hit_reg;
    logic [ITEM_WIDTH-1:0] hit_next;
    logic [ITEM_WIDTH-1:0] last_reg;
    logic [ITEM_WIDTH-1:0] last_next;
    logic                  active;
    logic                  hit;

    always_comb
    begin
        active = (MY_CNT < count);
        if (ctl.next_mode)
        begin
            hit = active && (MY_CNT == cursor);
        end
        else
        begin
            // first match wins, later cells just pass the word along
            hit = active && !found_in && (entry_reg == word);
        end
        found_next = found_in | hit;
        pos_next   = hit ? MY_POS : pos_in;
        hit_next   = hit ? entry_reg : hit_in;
        last_next  = (active && (MY_SUCC == count)) ? entry_reg : last_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (wr_addr == MY_POS))
        begin
            entry_reg <= wr_data;
        end
        found_reg <= found_next;
        pos_reg   <= pos_next;
        hit_reg   <= hit_next;
        last_reg  <= last_next;
    end

    assign found_out = found_reg;
    assign pos_out   = pos_reg;
    assign hit_out   = hit_reg;
    assign last_out  = last_reg;

endmodule

// ===== design/ult_ctrl.sv =====
module ult_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ult_pkg::op_t            operation,
    input  logic [ult_pkg::DATA_W-1:0] item_value,
    output logic                    done,
    output logic                    found,
    output logic [ult_pkg::DATA_W-1:0] item_out,
    output logic [CNT_W-1:0]        entry_count,
    output logic                    is_full,
    output ult_pkg::status_t        status,
    output ult_pkg::cell_ctl_t      ctl,
    output logic [CNT_W-1:0]        count,
    output logic [CNT_W-1:0]        cursor,
    output logic [ITEM_WIDTH-1:0]   word,
    output logic [IDX_W-1:0]        wr_addr,
    output logic [ITEM_WIDTH-1:0]   wr_data,
    input  logic                    tail_found,
    input  logic [IDX_W-1:0]        tail_pos,
    input  logic [ITEM_WIDTH-1:0]   tail_hit,
    input  logic [ITEM_WIDTH-1:0]   tail_last
);
    import ult_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [ITEM_WIDTH-1:0] word_reg, word_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [DATA_W-1:0]     item_reg, item_next;
    status_t               status_reg, status_next;
    logic [ITEM_WIDTH-1:0] word_in;
    logic                  wr_en;

    assign word_in = ITEM_WIDTH'(item_value);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        word_next   = word_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        item_next   = item_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = IDX_W'(count_reg);
        wr_data     = word_in;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    found_next  = 1'b0;
                    item_next   = DATA_W'(word_in);
                    status_next = STAT_OK;
                    op_next     = operation;
                    word_next   = word_in;
                    step_next   = '0;
                    case (operation) inside
                        OP_PUT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_GET, OP_DELETE, OP_NEXT:
                        begin
                            done_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_RESTART:
                        begin
                            cursor_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // token passes through each cell's registers on its way to the tail
                step_next = step_reg + IDX_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                found_next  = 1'b0;
                item_next   = DATA_W'(word_reg);
                status_next = STAT_OK;
                case (op_reg)
                    OP_GET:
                    begin
                        if (tail_found)
                        begin
                            found_next = 1'b1;
                            item_next  = DATA_W'(tail_hit);
                        end
                        else
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (tail_found)
                        begin
                            // last entry moves into the freed slot
                            found_next = 1'b1;
                            wr_en      = 1'b1;
                            wr_addr    = tail_pos;
                            wr_data    = tail_last;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                    OP_NEXT:
                    begin
                        if (tail_found)
                        begin
                            item_next   = DATA_W'(tail_hit);
                            cursor_next = cursor_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_PAST_END;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_PUT;
            word_reg   <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            item_reg   <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            word_reg   <= word_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            item_reg   <= item_next;
            status_reg <= status_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign item_out    = item_reg;
    assign entry_count = count_reg;
    assign is_full     = (count_reg == CAP_CNT);
    assign status      = status_reg;
    assign ctl         = '{next_mode: (op_reg == OP_NEXT), wr_en: wr_en};
    assign count       = count_reg;
    assign cursor      = cursor_reg;
    assign word        = word_reg;

endmodule

// ===== design/unsorted_list_table_top.sv =====
// Unsorted list of up to CAPACITY words held in a row of cells, one word per
// cell. Issue a command with start while busy is low. put, clear, restart and
// the unused codes finish at once: the result shows with done in the cycle
// after start and busy stays low. get, delete and next send a search token
// down the cell row, one cell per clock, so busy is high until done comes; this
// walk sets the rate. done is high for exactly one cycle and cannot be held
// off, so the receiver must take every result on the cycle it appears. Only
// words in the first entry_count cells are ever returned.
module unsorted_list_table_top #(
    parameter int  CAPACITY   = 64,
    parameter int  ITEM_WIDTH = 32,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ult_pkg::op_t               operation,
    input  logic [ult_pkg::DATA_W-1:0] item_value,
    output logic                       done,
    output logic                       found,
    output logic [ult_pkg::DATA_W-1:0] item_out,
    output logic [CNT_W-1:0]           entry_count,
    output logic                       is_full,
    output ult_pkg::status_t           status
);
    import ult_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    cell_ctl_t             ctl;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      cursor;
    logic [ITEM_WIDTH-1:0] word;
    logic [IDX_W-1:0]      wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;

    // token links, entry k feeds cell k
    logic                  link_found [CAPACITY+1];
    logic [IDX_W-1:0]      link_pos   [CAPACITY+1];
    logic [ITEM_WIDTH-1:0] link_hit   [CAPACITY+1];
    logic [ITEM_WIDTH-1:0] link_last  [CAPACITY+1];

    assign link_found[0] = 1'b0;
    assign link_pos[0]   = '0;
    assign link_hit[0]   = '0;
    assign link_last[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        ult_cell #(
            .ITEM_WIDTH (ITEM_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count),
            .cursor    (cursor),
            .word      (word),
            .wr_addr   (wr_addr),
            .wr_data   (wr_data),
            .found_in  (link_found[g]),
            .pos_in    (link_pos[g]),
            .hit_in    (link_hit[g]),
            .last_in   (link_last[g]),
            .found_out (link_found[g+1]),
            .pos_out   (link_pos[g+1]),
            .hit_out   (link_hit[g+1]),
            .last_out  (link_last[g+1])
        );
    end

    ult_ctrl #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .item_value  (item_value),
        .done        (done),
        .found       (found),
        .item_out    (item_out),
        .entry_count (entry_count),
        .is_full     (is_full),
        .status      (status),
        .ctl         (ctl),
        .count       (count),
        .cursor      (cursor),
        .word        (word),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .tail_found  (link_found[CAPACITY]),
        .tail_pos    (link_pos[CAPACITY]),
        .tail_hit    (link_hit[CAPACITY]),
        .tail_last   (link_last[CAPACITY])
    );

endmodule

// ===== design/ult_checker.sv =====
`include "unsorted_list_table_top_assert.svh"

module ult_checker #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input ult_pkg::op_t       operation,
    input logic               done,
    input logic [CNT_W-1:0]   entry_count,
    input logic               is_full,
    input ult_pkg::status_t   status
);
    import ult_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic search_cmd;
    logic clear_cmd;
    logic cap_hit;

    assign search_cmd = start && !busy
                        && (operation == OP_GET || operation == OP_DELETE
                            || operation == OP_NEXT);
    assign clear_cmd  = start && !busy && (operation == OP_CLEAR);
    assign cap_hit    = (entry_count == CAP_CNT);

    // searches hold the command port off
    `ULT_ASSERT_NEXT(a_search_busy, search_cmd, busy, "search word did not raise busy")
    `ULT_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
    `ULT_ASSERT_NOW(a_full_flag, done, is_full == cap_hit, "full flag disagrees with count")
    `ULT_ASSERT_NOW(a_drop_full, done && (status == STAT_FULL), is_full, "put dropped while not full")
    `ULT_ASSERT_NEXT(a_clear, clear_cmd, done && (entry_count == '0), "clear left entries")

endmodule

bind unsorted_list_table_top ult_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_ult_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .entry_count (entry_count),
    .is_full     (is_full),
    .status      (status)
);

// ===== tb/tb_top.sv =====
module tb_top;
    import ult_pkg::*;

    localparam int CAP         = 64;
    localparam int CNT_W       = 7;
    localparam int N_RANDOM    = 1400;
    localparam int QUIET_TAIL  = 200;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_PLAN      = 26;

    // codes the block leaves unused
    localparam op_t OP_SPARE_6 = 3'd6;
    localparam op_t OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] item;
        logic [CNT_W-1:0]  cnt;
        logic              full;
        status_t           st;
    } list_result_t;

    typedef struct {
        op_t               op;
        logic [DATA_W-1:0] value;
        bit                typed;
        list_result_t      res;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    op_t               operation;
    logic [DATA_W-1:0] item_value;
    logic              done;
    logic              found;
    logic [DATA_W-1:0] item_out;
    logic [CNT_W-1:0]  entry_count;
    logic              is_full;
    status_t           status;

    unsorted_list_table_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .item_value (item_value),
        .done       (done),
        .found      (found),
        .item_out   (item_out),
        .entry_count(entry_count),
        .is_full    (is_full),
        .status     (status)
    );

    // mirror of the list contents
    logic [DATA_W-1:0] list_words [CAP];
    int                list_len;
    int                walk_pos;

    list_result_t pending_results [$];
    plan_row_t    plan [N_PLAN];

    int  cycles;
    int  err_count;
    int  issued;
    int  results_seen;
    int  hits;
    int  drops;
    int  past_end;
    bit  idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic list_result_t apply_list_op(op_t op, logic [DATA_W-1:0] w);
        list_result_t r;
        int           hit;
        r = '{1'b0, w, '0, 1'b0, STAT_OK};
        hit = -1;
        // first match from the front
        if (op == OP_GET || op == OP_DELETE)
            for (int i = list_len - 1; i >= 0; i--)
                if (list_words[i] == w)
                    hit = i;
        case (op)
            OP_PUT:
                if (list_len >= CAP)
                    r.st = STAT_FULL;
                else
                begin
                    list_words[list_len] = w;
                    list_len++;
                end
            OP_GET:
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.item = list_words[hit];
                end
                else
                    r.st = STAT_NOT_FOUND;
            OP_DELETE:
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    list_words[hit] = list_words[list_len - 1];
                    list_len--;
                end
                else
                    r.st = STAT_NOT_FOUND;
            OP_CLEAR:
                list_len = 0;
            OP_RESTART:
                walk_pos = 0;
            OP_NEXT:
                if (walk_pos < list_len)
                begin
                    r.item = list_words[walk_pos];
                    walk_pos++;
                end
                else
                    r.st = STAT_PAST_END;
            default:
                ;
        endcase
        r.cnt = list_len[CNT_W-1:0];
        r.full = (list_len == CAP);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1, 2: pick_word = (list_len > 0) ?
                                 list_words[$urandom_range(0, list_len - 1)] : $urandom();
            3, 4:    pick_word = DATA_W'($urandom_range(0, 15));
            5:       pick_word = ~DATA_W'($urandom_range(0, 3));
            default: pick_word = $urandom();
        endcase
    endfunction

    task automatic issue(op_t op, logic [DATA_W-1:0] w, bit typed, list_result_t typed_res);
        list_result_t r;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        start = 1'b1;
        operation = op;
        item_value = w;
        do
            @(posedge clk);
        while (busy);
        r = apply_list_op(op, w);
        hits += r.found;
        drops += (r.st == STAT_FULL);
        past_end += (r.st == STAT_PAST_END);
        pending_results.push_back(typed ? typed_res : r);
        issued++;
    endtask

    task automatic issue_random(op_t op);
        issue(op, pick_word(), 1'b0, '0);
    endtask

    task automatic report_mismatch(string what, list_result_t want, list_result_t got);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%s: expected found=%0d item=%h count=%0d full=%0d status=%0d",
                     what, want.found, want.item, want.cnt, want.full, want.st);
            $display("    got found=%0d item=%h count=%0d full=%0d status=%0d",
                     got.found, got.item, got.cnt, got.full, got.st);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && done)
        begin
            got = '{found, item_out, entry_count, is_full, status};
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("word %0d", results_seen), want, got);
            end
        end
    end

    initial
    begin
        int r;
        int n;
        op_t op;

        cycles = 0;
        err_count = 0;
        issued = 0;
        results_seen = 0;
        hits = 0;
        drops = 0;
        past_end = 0;
        list_len = 0;
        walk_pos = 0;
        idle_on = 1'b1;
        start = 1'b0;
        operation = OP_PUT;
        item_value = '0;
        rst_n = 1'b0;

        plan = '{
            '{OP_NEXT,    32'h5A5A5A5A, 1'b1, '{1'b0, 32'h5A5A5A5A, 7'd0, 1'b0, STAT_PAST_END}},
            '{OP_GET,     32'hFFFFFFFF, 1'b1, '{1'b0, 32'hFFFFFFFF, 7'd0, 1'b0, STAT_NOT_FOUND}},
            '{OP_DELETE,  32'h00000001, 1'b1, '{1'b0, 32'h00000001, 7'd0, 1'b0, STAT_NOT_FOUND}},
            '{OP_PUT,     32'h00000000, 1'b1, '{1'b0, 32'h00000000, 7'd1, 1'b0, STAT_OK}},
            '{OP_PUT,     32'hFFFFFFFF, 1'b1, '{1'b0, 32'hFFFFFFFF, 7'd2, 1'b0, STAT_OK}},
            '{OP_PUT,     32'h80000000, 1'b1, '{1'b0, 32'h80000000, 7'd3, 1'b0, STAT_OK}},
            '{OP_PUT,     32'h00000001, 1'b1, '{1'b0, 32'h00000001, 7'd4, 1'b0, STAT_OK}},
            '{OP_GET,     32'hFFFFFFFF, 1'b1, '{1'b1, 32'hFFFFFFFF, 7'd4, 1'b0, STAT_OK}},
            '{OP_GET,     32'h00000000, 1'b1, '{1'b1, 32'h00000000, 7'd4, 1'b0, STAT_OK}},
            '{OP_GET,     32'h7FFFFFFF, 1'b1, '{1'b0, 32'h7FFFFFFF, 7'd4, 1'b0, STAT_NOT_FOUND}},
            '{OP_NEXT,    32'h0000FFFF, 1'b1, '{1'b0, 32'h00000000, 7'd4, 1'b0, STAT_OK}},
            '{OP_NEXT,    32'h0000FFFF, 1'b1, '{1'b0, 32'hFFFFFFFF, 7'd4, 1'b0, STAT_OK}},
            '{OP_DELETE,  32'h00000000, 1'b1, '{1'b1, 32'h00000000, 7'd3, 1'b0, STAT_OK}},
            '{OP_NEXT,    32'hFFFF0000, 1'b0, '0},
            '{OP_NEXT,    32'hFFFF0000, 1'b0, '0},
            '{OP_RESTART, 32'hA5A5A5A5, 1'b0, '0},
            '{OP_NEXT,    32'h00000000, 1'b0, '0},
            '{OP_DELETE,  32'h80000000, 1'b0, '0},
            '{OP_SPARE_6, 32'hDEADBEEF, 1'b0, '0},
            '{OP_SPARE_7, 32'h00000000, 1'b0, '0},
            '{OP_CLEAR,   32'h12345678, 1'b0, '0},
            '{OP_NEXT,    32'h87654321, 1'b0, '0},
            '{OP_PUT,     32'h12345678, 1'b0, '0},
            '{OP_NEXT,    32'h00000000, 1'b0, '0},
            '{OP_RESTART, 32'h00000000, 1'b0, '0},
            '{OP_NEXT,    32'hFFFFFFFF, 1'b0, '0}
        };

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            issue(plan[i].op, plan[i].value, plan[i].typed, plan[i].res);

        n = 0;
        while (n < N_RANDOM)
        begin
            idle_on = (n < N_RANDOM - QUIET_TAIL);
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                // fill to capacity, then push past it
                while (list_len < CAP)
                begin
                    issue_random(OP_PUT);
                    n++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    issue_random(OP_PUT);
                    n++;
                end
            end
            else if (r == 1)
            begin
                // walk the whole list and one past the end
                issue_random(OP_RESTART);
                n++;
                for (int k = list_len + 1; k > 0; k--)
                begin
                    issue_random(OP_NEXT);
                    n++;
                end
            end
            else
                repeat (20)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        op = OP_PUT;
                    else if (r < 55)
                        op = OP_GET;
                    else if (r < 75)
                        op = OP_DELETE;
                    else if (r < 88)
                        op = OP_NEXT;
                    else if (r < 93)
                        op = OP_RESTART;
                    else if (r < 96)
                        op = OP_CLEAR;
                    else if (r < 98)
                        op = OP_SPARE_6;
                    else
                        op = OP_SPARE_7;
                    issue_random(op);
                    n++;
                end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAP + 4) @(posedge clk);

        $display("%0d words issued, %0d results checked over %0d cycles",
                 issued, results_seen, cycles);
        $display("%0d get/delete hits, %0d puts dropped on a full list, %0d reads past the end",
                 hits, drops, past_end);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
